/* src/bpfa_pkg.sv */
// Shared constants, types and helpers of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int REGIONS          = 3;
    localparam int MAX_PAGES        = 4096;
    localparam int FRAME_BITS       = 36;
    localparam int PAGE_CNT_BITS    = 13;
    localparam int PAGE_IDX_BITS    = 12;
    localparam int WORD_BITS        = 64;
    localparam int BIT_IDX_BITS     = 6;
    localparam int WORD_IDX_BITS    = PAGE_IDX_BITS - BIT_IDX_BITS;
    localparam int WORDS_PER_REGION = MAX_PAGES / WORD_BITS;
    localparam int MEM_DEPTH        = REGIONS * WORDS_PER_REGION;
    localparam int ADDR_BITS        = 2 + WORD_IDX_BITS;
    localparam int CFG_IDX_BITS     = 3;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_OUT_OF_PAGES = 3'd1;
    localparam logic [2:0] ST_NO_REGION    = 3'd2;
    localparam logic [2:0] ST_OUT_OF_RANGE = 3'd3;
    localparam logic [2:0] ST_DOUBLE_FREE  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R0_BASE      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R0_PAGES     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R1_BASE      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R1_PAGES     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R2_BASE      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R2_PAGES     = 3'd6;

    typedef struct packed {
        logic [1:0]                                 count;
        logic [REGIONS-1:0][FRAME_BITS-1:0]         base;
        logic [REGIONS-1:0][PAGE_CNT_BITS-1:0]      pages;
    } cfg_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [FRAME_BITS-1:0] frame;
    } result_t;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

    function automatic logic [PAGE_CNT_BITS-1:0] pages_sat(input logic [PAGE_CNT_BITS-1:0] p);
        if (p > PAGE_CNT_BITS'(MAX_PAGES)) begin
            return PAGE_CNT_BITS'(MAX_PAGES);
        end
        return p;
    endfunction

endpackage

/* src/bitmap_page_frame_allocator.sv */
// Page frame allocator over up to three regions with one used bitmap per region.
//
// Each request (allocate or free) gives one result beat. The block works on one
// request at a time; a new request is taken as soon as the previous result sits
// in the output register, even if the consumer has not taken it yet. An allocate
// walks the bitmap one 64-bit word at a time through a single-port word memory
// with registered reads, starting at the hint word and stepping on to later
// regions from their first word. A free picks its region with one compare per
// region per cycle and then, if the frame is in range, reads the page's word and
// clears its bit unless the page is already free. Bitmap words carry valid bits
// cleared by reset, so the block is usable right after reset with no clearing pass.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [39:0]             s_tdata,   // [35:0] page_frame
    input  logic                    s_tuser,   // [0] kind
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [39:0]             m_tdata    // [2:0] status, [38:3] granted_frame
);

    cfg_t                 cfg_reg;
    logic                 m_tvalid_reg;
    result_t              out_reg;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;
    mem_req_t             mem_req;
    logic [WORD_BITS-1:0] mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count <= 2'd1;
            cfg_reg.base  <= '0;
            cfg_reg.pages <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_REGION_COUNT: cfg_reg.count    <= cfg_wdata[1:0];
                CFG_R0_BASE:      cfg_reg.base[0]  <= cfg_wdata;
                CFG_R0_PAGES:     cfg_reg.pages[0] <= cfg_wdata[PAGE_CNT_BITS-1:0];
                CFG_R1_BASE:      cfg_reg.base[1]  <= cfg_wdata;
                CFG_R1_PAGES:     cfg_reg.pages[1] <= cfg_wdata[PAGE_CNT_BITS-1:0];
                CFG_R2_BASE:      cfg_reg.base[2]  <= cfg_wdata;
                CFG_R2_PAGES:     cfg_reg.pages[2] <= cfg_wdata[PAGE_CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    bpfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_kind  (s_tuser),
        .req_frame (s_tdata[FRAME_BITS-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    bpfa_word_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata   (mem_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.frame, out_reg.status};

endmodule

/* src/bpfa_word_mem.sv */
// Bitmap word store with per-word valid bits; an unwritten word reads as all free.
module bpfa_word_mem
    import bpfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mem_req_t             req,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [0:MEM_DEPTH-1];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* src/bpfa_ctrl.sv */
// Request sequencer: word-by-word allocate scan and region pick plus check for free.
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  req_kind,
    input  logic [FRAME_BITS-1:0] req_frame,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res,
    output mem_req_t              mem_req,
    input  logic [WORD_BITS-1:0]  mem_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_A_CHK  = 3'd1;
    localparam logic [2:0] S_A_EVAL = 3'd2;
    localparam logic [2:0] S_A_ADD  = 3'd3;
    localparam logic [2:0] S_F_SEL  = 3'd4;
    localparam logic [2:0] S_F_RNG  = 3'd5;
    localparam logic [2:0] S_F_EVAL = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [1:0]               r_reg, r_next;
    logic [WORD_IDX_BITS:0]   j_reg, j_next;
    logic [1:0]               sel_reg, sel_next;
    logic                     found_reg, found_next;
    logic [FRAME_BITS-1:0]    frame_reg, frame_next;
    logic [PAGE_IDX_BITS-1:0] num_reg, num_next;
    logic [BIT_IDX_BITS-1:0]  bit_reg, bit_next;
    logic [1:0]               hint_region_reg, hint_region_next;
    logic [PAGE_IDX_BITS-1:0] hint_page_reg, hint_page_next;
    result_t                  res_reg, res_next;

    logic [PAGE_CNT_BITS-1:0] pages_r;
    logic [PAGE_CNT_BITS:0]   pages_round;
    logic [WORD_IDX_BITS+1:0] words_r;
    logic [PAGE_CNT_BITS-1:0] left;
    logic [WORD_BITS-1:0]     valid_mask;
    logic [WORD_BITS-1:0]     avail;
    logic [BIT_IDX_BITS-1:0]  low_bit;
    logic [FRAME_BITS-1:0]    diff;
    logic [PAGE_IDX_BITS-1:0] page_idx;

    always_comb begin
        pages_r     = pages_sat(cfg.pages[r_reg]);
        pages_round = {1'b0, pages_r} + (PAGE_CNT_BITS+1)'(WORD_BITS - 1);
        words_r     = pages_round[PAGE_CNT_BITS:BIT_IDX_BITS];
        left        = pages_r - {j_reg, BIT_IDX_BITS'(0)};
        if (left >= PAGE_CNT_BITS'(WORD_BITS)) begin
            valid_mask = '1;
        end else begin
            valid_mask = (WORD_BITS'(1) << left[BIT_IDX_BITS-1:0]) - WORD_BITS'(1);
        end
        avail   = ~mem_rdata & valid_mask;
        // priority pick of the lowest free page in the word
        low_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                low_bit = BIT_IDX_BITS'(b);
            end
        end
        diff     = frame_reg - cfg.base[sel_reg];
        page_idx = {j_reg[WORD_IDX_BITS-1:0], low_bit};
    end

    always_comb begin
        state_next       = state_reg;
        r_next           = r_reg;
        j_next           = j_reg;
        sel_next         = sel_reg;
        found_next       = found_reg;
        frame_next       = frame_reg;
        num_next         = num_reg;
        bit_next         = bit_reg;
        hint_region_next = hint_region_reg;
        hint_page_next   = hint_page_reg;
        res_next         = res_reg;
        mem_req          = '0;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    frame_next = req_frame;
                    if (req_kind) begin
                        r_next     = 2'd0;
                        found_next = 1'b0;
                        sel_next   = 2'd0;
                        state_next = S_F_SEL;
                    end else begin
                        r_next     = hint_region_reg;
                        j_next     = {1'b0, hint_page_reg[PAGE_IDX_BITS-1:BIT_IDX_BITS]};
                        state_next = S_A_CHK;
                    end
                end
            end
            S_A_CHK: begin
                if (r_reg >= cfg.count) begin
                    res_next   = '{status: ST_OUT_OF_PAGES, frame: '0};
                    state_next = S_DONE;
                end else if ({1'b0, j_reg} >= words_r) begin
                    // advance to the next region from its first word
                    r_next = r_reg + 2'd1;
                    j_next = '0;
                end else begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = {r_reg, j_reg[WORD_IDX_BITS-1:0]};
                    state_next    = S_A_EVAL;
                end
            end
            S_A_EVAL: begin
                if (avail != '0) begin
                    mem_req.wr_en    = 1'b1;
                    mem_req.addr     = {r_reg, j_reg[WORD_IDX_BITS-1:0]};
                    mem_req.wdata    = mem_rdata | (WORD_BITS'(1) << low_bit);
                    hint_region_next = r_reg;
                    hint_page_next   = page_idx;
                    bit_next         = low_bit;
                    state_next       = S_A_ADD;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_A_CHK;
                end
            end
            S_A_ADD: begin
                res_next.status = ST_OK;
                res_next.frame  = cfg.base[r_reg]
                                + FRAME_BITS'({j_reg[WORD_IDX_BITS-1:0], bit_reg});
                state_next      = S_DONE;
            end
            S_F_SEL: begin
                if (r_reg >= cfg.count) begin
                    if (found_reg) begin
                        state_next = S_F_RNG;
                    end else begin
                        res_next   = '{status: ST_NO_REGION, frame: '0};
                        state_next = S_DONE;
                    end
                end else begin
                    // keep the highest base at or below the frame; ties keep the lower region
                    if (cfg.base[r_reg] <= frame_reg
                        && (!found_reg || cfg.base[r_reg] > cfg.base[sel_reg])) begin
                        found_next = 1'b1;
                        sel_next   = r_reg;
                    end
                    r_next = r_reg + 2'd1;
                end
            end
            S_F_RNG: begin
                if (diff >= FRAME_BITS'(pages_sat(cfg.pages[sel_reg]))) begin
                    res_next   = '{status: ST_OUT_OF_RANGE, frame: '0};
                    state_next = S_DONE;
                end else begin
                    num_next      = diff[PAGE_IDX_BITS-1:0];
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = {sel_reg, diff[PAGE_IDX_BITS-1:BIT_IDX_BITS]};
                    state_next    = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                if (!mem_rdata[num_reg[BIT_IDX_BITS-1:0]]) begin
                    res_next = '{status: ST_DOUBLE_FREE, frame: '0};
                end else begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = {sel_reg, num_reg[PAGE_IDX_BITS-1:BIT_IDX_BITS]};
                    mem_req.wdata = mem_rdata
                                  & ~(WORD_BITS'(1) << num_reg[BIT_IDX_BITS-1:0]);
                    if (hint_region_reg > sel_reg
                        || (hint_region_reg == sel_reg && hint_page_reg > num_reg)) begin
                        hint_region_next = sel_reg;
                        hint_page_next   = num_reg;
                    end
                    res_next = '{status: ST_OK, frame: '0};
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            hint_region_reg <= '0;
            hint_page_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            hint_region_reg <= hint_region_next;
            hint_page_reg   <= hint_page_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg     <= r_next;
        j_reg     <= j_next;
        sel_reg   <= sel_next;
        found_reg <= found_next;
        frame_reg <= frame_next;
        num_reg   <= num_next;
        bit_reg   <= bit_next;
        res_reg   <= res_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the bitmap page frame allocator.
`timescale 1ns / 1ps

module tb_top
    import bpfa_pkg::*;
();

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;
    localparam logic [FRAME_BITS-1:0] TOP_FRAME = {FRAME_BITS{1'b1}};

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [FRAME_BITS-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [39:0]             s_tdata   = '0;   // [35:0] page_frame
    logic                    s_tuser   = 1'b0; // [0] kind
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [39:0]             m_tdata;          // [2:0] status, [38:3] granted_frame

    bitmap_page_frame_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow of the allocator state and registers
    logic [WORD_BITS-1:0]     used_map [MEM_DEPTH];
    logic [1:0]               cur_count;
    logic [FRAME_BITS-1:0]    cur_base [REGIONS];
    logic [PAGE_CNT_BITS-1:0] cur_pages [REGIONS];
    logic [1:0]               hint_reg;
    logic [PAGE_IDX_BITS-1:0] hint_pg;

    result_t               pending_results [$];
    logic [FRAME_BITS-1:0] granted_frames [$];
    result_t               want;

    int  errors          = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  layouts_written = 0;
    int  status_seen [5] = '{default: 0};
    bit  gaps_on         = 1'b1;
    bit  stall_on        = 1'b1;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(64'd20_000_000);
        $display("Timeout at %0t with %0d results outstanding", $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // random backpressure on the result side
    always begin
        @(negedge aclk);
        if (stall_on && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing pending: status %0d frame %h",
                         $time, m_tdata[2:0], m_tdata[38:3]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[38:3] !== want.frame) begin
                    $display("%0t: granted_frame mismatch: expected %h, actual %h",
                             $time, want.frame, m_tdata[38:3]);
                    errors++;
                end
                if (want.status <= ST_DOUBLE_FREE) status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    function automatic int pages_in(input int r);
        return (cur_pages[r] > PAGE_CNT_BITS'(MAX_PAGES)) ? MAX_PAGES : int'(cur_pages[r]);
    endfunction

    function automatic void predict_alloc(output result_t res);
        int r;
        int j;
        int b;
        int pages;
        int words;
        int left;
        int idx;
        logic [WORD_BITS-1:0] valid;
        logic [WORD_BITS-1:0] avail;
        res.status = ST_OUT_OF_PAGES;
        res.frame  = '0;
        for (r = int'(hint_reg); r < int'(cur_count); r++) begin
            pages = pages_in(r);
            words = (pages + WORD_BITS - 1) / WORD_BITS;
            for (j = (r == int'(hint_reg)) ? int'(hint_pg) / WORD_BITS : 0; j < words; j++) begin
                left  = pages - j * WORD_BITS;
                valid = (left >= WORD_BITS) ? '1 : ((64'd1 << left) - 64'd1);
                avail = ~used_map[r * WORDS_PER_REGION + j] & valid;
                if (avail != '0) begin
                    b = 0;
                    while (!avail[b]) b++;
                    idx = j * WORD_BITS + b;
                    used_map[r * WORDS_PER_REGION + j][b] = 1'b1;
                    hint_reg   = 2'(r);
                    hint_pg    = PAGE_IDX_BITS'(idx);
                    res.status = ST_OK;
                    res.frame  = cur_base[r] + FRAME_BITS'(idx);
                    return;
                end
            end
        end
    endfunction

    function automatic void predict_free(input logic [FRAME_BITS-1:0] frame, output result_t res);
        int r;
        int sel;
        int addr;
        bit found;
        logic [FRAME_BITS-1:0] num;
        found     = 1'b0;
        sel       = 0;
        res.frame = '0;
        for (r = 0; r < int'(cur_count); r++) begin
            if (cur_base[r] <= frame && (!found || cur_base[r] > cur_base[sel])) begin
                found = 1'b1;
                sel   = r;
            end
        end
        if (!found) begin
            res.status = ST_NO_REGION;
            return;
        end
        num = frame - cur_base[sel];
        if (num >= FRAME_BITS'(pages_in(sel))) begin
            res.status = ST_OUT_OF_RANGE;
            return;
        end
        addr = sel * WORDS_PER_REGION + int'(num[PAGE_IDX_BITS-1:BIT_IDX_BITS]);
        if (!used_map[addr][num[BIT_IDX_BITS-1:0]]) begin
            res.status = ST_DOUBLE_FREE;
            return;
        end
        used_map[addr][num[BIT_IDX_BITS-1:0]] = 1'b0;
        if (int'(hint_reg) > sel ||
            (int'(hint_reg) == sel && hint_pg > num[PAGE_IDX_BITS-1:0])) begin
            hint_reg = 2'(sel);
            hint_pg  = num[PAGE_IDX_BITS-1:0];
        end
        res.status = ST_OK;
    endfunction

    task automatic send_req(input logic kind, input logic [FRAME_BITS-1:0] frame,
                            output result_t pred);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, frame};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_ALLOC) predict_alloc(pred);
        else predict_free(frame, pred);
        pending_results.push_back(pred);
        requests_sent++;
    endtask

    task automatic alloc_page;
        result_t got;
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_req(KIND_ALLOC, junk[FRAME_BITS-1:0], got);
        if (got.status == ST_OK) granted_frames.push_back(got.frame);
    endtask

    task automatic free_frame(input logic [FRAME_BITS-1:0] frame);
        result_t got;
        send_req(KIND_FREE, frame, got);
    endtask

    // hold the request side quiet until every result is back
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [FRAME_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_REGION_COUNT: cur_count    = value[1:0];
            CFG_R0_BASE:      cur_base[0]  = value;
            CFG_R0_PAGES:     cur_pages[0] = value[PAGE_CNT_BITS-1:0];
            CFG_R1_BASE:      cur_base[1]  = value;
            CFG_R1_PAGES:     cur_pages[1] = value[PAGE_CNT_BITS-1:0];
            CFG_R2_BASE:      cur_base[2]  = value;
            CFG_R2_PAGES:     cur_pages[2] = value[PAGE_CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_layout(input logic [FRAME_BITS-1:0] count,
                              input logic [FRAME_BITS-1:0] b0, input logic [FRAME_BITS-1:0] p0,
                              input logic [FRAME_BITS-1:0] b1, input logic [FRAME_BITS-1:0] p1,
                              input logic [FRAME_BITS-1:0] b2, input logic [FRAME_BITS-1:0] p2);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_REGION_COUNT, count);
        write_reg(CFG_R0_BASE, b0);
        write_reg(CFG_R0_PAGES, p0);
        write_reg(CFG_R1_BASE, b1);
        write_reg(CFG_R1_PAGES, p1);
        write_reg(CFG_R2_BASE, b2);
        write_reg(CFG_R2_PAGES, p2);
        // the spare index must not disturb anything
        write_reg(CFG_SPARE, junk[FRAME_BITS-1:0]);
        end_writes();
        layouts_written++;
    endtask

    task automatic random_layout(input bit wide);
        logic [63:0] rnd;
        logic [63:0] junk;
        logic [FRAME_BITS-1:0] anchor;
        logic [FRAME_BITS-1:0] base_pick [REGIONS];
        logic [FRAME_BITS-1:0] page_pick [REGIONS];
        logic [FRAME_BITS-1:0] count_word;
        int mode;
        int r;
        int p;
        rnd    = {$urandom, $urandom};
        anchor = rnd[FRAME_BITS-1:0];
        mode   = $urandom_range(0, 3);
        for (r = 0; r < REGIONS; r++) begin
            rnd = {$urandom, $urandom};
            case (mode)
                0: base_pick[r] = rnd[FRAME_BITS-1:0];
                1: base_pick[r] = anchor + FRAME_BITS'($urandom_range(0, 3) * $urandom_range(0, 120));
                2: base_pick[r] = TOP_FRAME - FRAME_BITS'($urandom_range(0, 400));
                default: base_pick[r] = FRAME_BITS'($urandom_range(0, 1500));
            endcase
            if (wide) begin
                case ($urandom_range(0, 2))
                    0: p = MAX_PAGES;
                    1: p = 8191;
                    default: p = $urandom_range(4000, 8191);
                endcase
            end else begin
                case ($urandom_range(0, 7))
                    0: p = 0;
                    1: p = WORD_BITS;
                    2: p = WORD_BITS + 1;
                    default: p = $urandom_range(1, 200);
                endcase
            end
            junk = {$urandom, $urandom};
            page_pick[r] = {(($urandom_range(0, 5) == 0) ? junk[22:0] : 23'd0), 13'(p)};
        end
        junk = {$urandom, $urandom};
        count_word = {(($urandom_range(0, 1) == 0) ? junk[33:0] : 34'd0),
                      2'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3))};
        set_layout(count_word, base_pick[0], page_pick[0], base_pick[1], page_pick[1],
                   base_pick[2], page_pick[2]);
    endtask

    // mostly frames handed out earlier, then frames near a region, then anything
    task automatic free_some_page;
        logic [63:0] rnd;
        logic [FRAME_BITS-1:0] frame;
        int pick;
        int r;
        pick = $urandom_range(0, 9);
        rnd  = {$urandom, $urandom};
        if (pick < 6 && granted_frames.size() > 0) begin
            r     = $urandom_range(0, granted_frames.size() - 1);
            frame = granted_frames[r];
            granted_frames.delete(r);
        end else if (pick < 9) begin
            r     = $urandom_range(0, REGIONS - 1);
            frame = cur_base[r] + FRAME_BITS'($urandom_range(0, pages_in(r) + 8));
        end else begin
            frame = rnd[FRAME_BITS-1:0];
        end
        free_frame(frame);
    endtask

    task automatic random_request(input int alloc_pct);
        if ($urandom_range(0, 99) < alloc_pct) alloc_page();
        else free_some_page();
    endtask

    task automatic test_after_reset;
        alloc_page();
        free_frame('0);
        free_frame(TOP_FRAME);
    endtask

    task automatic test_partial_word;
        drain();
        set_layout(1, 0, 3, 0, 0, 0, 0);
        repeat (4) alloc_page();
        free_frame(1);
        free_frame(1);
        alloc_page();
        free_frame(3);
    endtask

    task automatic test_region_select;
        drain();
        set_layout(3, 'h10, 2, 'h800, 8191, TOP_FRAME - 1, 5);
        alloc_page();
        free_frame('h0f);
        free_frame('h800 + MAX_PAGES);
        free_frame(TOP_FRAME);
        drain();
        // empty middle region, then grants that wrap past the top frame
        set_layout(3, 'h10, 2, 'h800, 0, TOP_FRAME - 1, 5);
        repeat (3) alloc_page();
        free_frame('h800);
        drain();
        // hint now sits past the only region left in use
        write_reg(CFG_REGION_COUNT, 1);
        end_writes();
        alloc_page();
        free_frame('h10);
        alloc_page();
    endtask

    task automatic test_equal_bases;
        drain();
        set_layout(2, 'h100, 10, 'h100, 10, 0, 0);
        free_frame('h100);
        alloc_page();
    endtask

    task automatic test_no_regions;
        drain();
        set_layout(0, 0, 100, 0, 100, 0, 100);
        alloc_page();
        free_frame('h5);
    endtask

    task automatic test_random_traffic;
        int phase;
        int n;
        int alloc_pct;
        for (phase = 0; phase < 7; phase++) begin
            drain();
            random_layout(phase == 3);
            stall_on  = (phase % 3 != 2);
            gaps_on   = (phase % 3 != 2);
            alloc_pct = $urandom_range(35, 70);
            for (n = 0; n < 105; n++) random_request(alloc_pct);
        end
    endtask

    task automatic test_steady_stream;
        int n;
        drain();
        random_layout(1'b0);
        stall_on = 1'b0;
        gaps_on  = 1'b0;
        for (n = 0; n < 100; n++) random_request(55);
    endtask

    initial begin
        foreach (used_map[i]) used_map[i] = '0;
        cur_count = 2'd1;
        foreach (cur_base[i]) begin
            cur_base[i]  = '0;
            cur_pages[i] = '0;
        end
        hint_reg = '0;
        hint_pg  = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_partial_word();
        test_region_select();
        test_equal_bases();
        test_no_regions();
        test_random_traffic();
        test_steady_stream();
        drain();

        $display("Sent %0d requests across %0d register layouts, checked %0d results",
                 requests_sent, layouts_written, results_checked);
        $display("Statuses: ok %0d, out_of_pages %0d, no_region %0d, out_of_range %0d, %s %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 "double_free", status_seen[4]);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
